[design/rel_pkg.sv]
// Shared types and constants of the replicated error log ring.
package rel_pkg;

  // Default geometry handed to the top level parameters
  localparam int DEF_SLOTS      = 128;
  localparam int DEF_MAX_COPIES = 4;

  // Field widths fixed by the word formats
  localparam int CODE_W  = 32;
  localparam int MODE_W  = 2;
  localparam int CSEL_W  = 2;
  localparam int SLOT_W  = 7;
  localparam int STAT_W  = 2;
  localparam int RING_W  = 8;
  localparam int COPY_W  = 3;
  localparam int CNT_W   = 4;  // copy counters, hold up to 15 copies
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CODE_W-1:0] ERASED = '1;

  // Register reset values
  localparam logic [RING_W-1:0] RING_RST   = 8'd128;
  localparam logic [COPY_W-1:0] COPIES_RST = 3'd2;

  // Register select, taken from paddr bit 2
  localparam logic REG_RING   = 1'b0;
  localparam logic REG_COPIES = 1'b1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_LOG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOCAND = 2'd2;

  // Running vote outcome
  typedef struct packed {
    logic [CODE_W-1:0] cand;
    logic              chosen;
    logic              fix;     // two or more reads disagreed
  } vote_res_t;

endpackage

[design/rel_in_if.sv]
// Input channel: one log request word per handshake.
interface rel_in_if;
  logic                         valid;
  logic                         ready;
  logic [rel_pkg::MODE_W-1:0]   mode;
  logic [rel_pkg::CODE_W-1:0]   log_code;
  logic [rel_pkg::CSEL_W-1:0]   copy_select;
  logic [rel_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, mode, log_code, copy_select, slot, input ready);
  modport sink   (input valid, mode, log_code, copy_select, slot, output ready);
endinterface

[design/rel_out_if.sv]
// Output channel: one result word per handshake.
interface rel_out_if;
  logic                         valid;
  logic                         ready;
  logic [rel_pkg::STAT_W-1:0]   status;
  logic [rel_pkg::CODE_W-1:0]   read_code;
  logic                         repaired;

  modport source (output valid, status, read_code, repaired, input ready);
  modport sink   (input valid, status, read_code, repaired, output ready);
endinterface

[design/replicated_error_log_ring.sv]
// Top level: request sequencer, ring pointers and config registers.
//
//  channel   dir  handshake       words
//  in_ch     in   valid/ready     mode, log_code, copy_select, slot
//  out_ch    out  valid/ready     status, read_code, repaired
//  apb       in   psel/penable    ring_entries @0x0, copy_count @0x4
//
// One request at a time. Log writes every copy; take reads the copies, votes and
// rewrites them when the vote calls for a fix; raw writes at most one word; empty
// take and unused mode go straight to S_FIN. Copy reads overlap the vote. After
// reset the store is erased one word a cycle, all SLOTS*MAX_COPIES words (512 by
// default), and no request is taken until that is done.
// A finished request waits in S_FIN only while the previous result is unread.
module replicated_error_log_ring #(
  parameter int SLOTS      = rel_pkg::DEF_SLOTS,
  parameter int MAX_COPIES = rel_pkg::DEF_MAX_COPIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rel_pkg::APB_AW-1:0]   paddr,
  input  logic [rel_pkg::APB_DW-1:0]   pwdata,
  output logic [rel_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  rel_in_if.sink                       in_ch,
  rel_out_if.source                    out_ch
);
  import rel_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = ($clog2(SLOTS + 1) > RING_W) ? $clog2(SLOTS + 1) : RING_W;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOG    = 7'b0000100,
    S_READ   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_REPAIR = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  // "raw" shares the write path; it is handled as a one-shot inside S_LOG
  state_t state;

  logic [RING_W-1:0] ring_entries;
  logic [COPY_W-1:0] copy_count;

  logic [MODE_W-1:0] it_mode;
  logic [CODE_W-1:0] it_code;
  logic [CSEL_W-1:0] it_csel;
  logic [SLOT_W-1:0] it_slot;

  logic [SW-1:0]     oldest;
  logic [SW-1:0]     write_ptr;
  logic [CNT_W-1:0]  wc;
  logic [CNT_W-1:0]  ri;
  logic [CNT_W-1:0]  vc;
  logic              rd_vld;

  logic [STAT_W-1:0] res_status;
  logic [CODE_W-1:0] res_code;
  logic              res_rep;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [CODE_W-1:0] out_code;
  logic              out_rep;

  logic [CW-1:0]     ent_eff;
  logic [CNT_W-1:0]  cp_eff;
  logic              accept;
  logic              raw_ok;
  logic              wr_more;
  logic              rd_issue;
  logic [SW-1:0]     next_write;

  logic              st_we;
  logic [CNT_W-1:0]  st_wcopy;
  logic [SW-1:0]     st_wslot;
  logic [CODE_W-1:0] st_wdata;
  logic [CODE_W-1:0] st_rdata;
  logic              st_busy;
  logic              vote_start;
  vote_res_t         vote;

  // pointer advance with wrap to slot one
  function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] p,
                                              input logic [CW-1:0] lim);
    logic [CW-1:0] n;
    begin
      n = CW'(p) + CW'(1);
      if (n >= lim) begin
        ring_next = SW'(1);
      end else begin
        ring_next = SW'(n);
      end
    end
  endfunction

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_entries <= RING_RST;
      copy_count   <= COPIES_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RING:   ring_entries <= pwdata[RING_W-1:0];
        REG_COPIES: copy_count   <= pwdata[COPY_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RING:   prdata = APB_DW'(ring_entries);
      REG_COPIES: prdata = APB_DW'(copy_count);
      default:    prdata = '0;
    endcase
  end

  // effective geometry
  assign ent_eff = (CW'(ring_entries) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(ring_entries);
  assign cp_eff  = (CNT_W'(copy_count) > CNT_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES)
                                                             : CNT_W'(copy_count);

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign vote_start  = accept && (in_ch.mode == MODE_TAKE);

  assign raw_ok     = (CNT_W'(it_csel) < CNT_W'(MAX_COPIES)) && (CW'(it_slot) < CW'(SLOTS));
  assign wr_more    = (wc < cp_eff);
  assign rd_issue   = (state == S_READ) && (ri < cp_eff);
  assign next_write = ring_next(write_ptr, ent_eff);

  // store write port select
  always_comb begin
    st_we    = 1'b0;
    st_wcopy = wc;
    st_wslot = write_ptr;
    st_wdata = it_code;
    case (state)
      S_LOG: begin
        if (it_mode == MODE_RAW) begin
          st_we    = raw_ok;
          st_wcopy = CNT_W'(it_csel);
          st_wslot = SW'(it_slot);
        end else begin
          st_we = wr_more;
        end
      end
      S_REPAIR: begin
        st_we    = wr_more;
        st_wslot = oldest;
        st_wdata = vote.cand;
      end
      default: ;
    endcase
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      oldest    <= SW'(1);
      write_ptr <= SW'(1);
      wc        <= '0;
      ri        <= '0;
      vc        <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      case (state)
        S_CLEAR: begin
          if (!st_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            it_mode    <= in_ch.mode;
            it_code    <= in_ch.log_code;
            it_csel    <= in_ch.copy_select;
            it_slot    <= in_ch.slot;
            wc         <= '0;
            ri         <= '0;
            vc         <= '0;
            res_status <= ST_OK;
            res_code   <= '0;
            res_rep    <= 1'b0;
            case (in_ch.mode)
              MODE_LOG, MODE_RAW: state <= S_LOG;
              MODE_TAKE: begin
                if (oldest == write_ptr) begin
                  res_status <= ST_EMPTY;
                  res_code   <= ERASED;
                  state      <= S_FIN;
                end else begin
                  state <= S_READ;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_LOG: begin
          if (it_mode == MODE_RAW) begin
            state <= S_FIN;
          end else if (wr_more) begin
            wc <= wc + CNT_W'(1);
          end else begin
            if (next_write == oldest) begin
              oldest <= ring_next(oldest, ent_eff);
            end
            write_ptr <= next_write;
            state     <= S_FIN;
          end
        end
        S_READ: begin
          if (rd_issue) begin
            ri <= ri + CNT_W'(1);
          end
          if (rd_vld) begin
            vc <= vc + CNT_W'(1);
          end
          if ((vc == cp_eff) && !rd_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!vote.chosen) begin
            res_status <= ST_NOCAND;
            res_code   <= ERASED;
            state      <= S_FIN;
          end else begin
            res_code <= vote.cand;
            if (vote.fix) begin
              res_rep <= 1'b1;
              wc      <= '0;
              state   <= S_REPAIR;
            end else begin
              oldest <= ring_next(oldest, ent_eff);
              state  <= S_FIN;
            end
          end
        end
        S_REPAIR: begin
          if (wr_more) begin
            wc <= wc + CNT_W'(1);
          end else begin
            oldest <= ring_next(oldest, ent_eff);
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (!out_valid || out_ch.ready)) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_code   <= res_code;
      out_rep    <= res_rep;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.read_code = out_code;
  assign out_ch.repaired  = out_rep;

  rel_store #(
    .SLOTS      (SLOTS),
    .MAX_COPIES (MAX_COPIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (st_we),
    .wr_copy (st_wcopy),
    .wr_slot (st_wslot),
    .wr_data (st_wdata),
    .rd_en   (rd_issue),
    .rd_copy (ri),
    .rd_slot (oldest),
    .rd_data (st_rdata),
    .busy    (st_busy)
  );

  rel_vote u_vote (
    .clk   (clk),
    .rst   (rst),
    .start (vote_start),
    .step  (rd_vld),
    .value (st_rdata),
    .res   (vote)
  );

`ifndef SYNTHESIS
  // no request taken while the store is still being erased
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !st_busy)
    else $error("request accepted during erase sweep");

  // pointers always address a real slot
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(oldest) < CW'(SLOTS)) && (CW'(write_ptr) < CW'(SLOTS)))
    else $error("ring pointer out of range");

  // the vote never consumes more words than were read
  a_vote_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (vc <= ri))
    else $error("vote step without a read");

  // a repair is only reported with a good status
  a_rep_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rep) |-> (out_status == ST_OK))
    else $error("repair flagged on a failed take");
`endif

endmodule

[design/rel_store.sv]
// Log store: all copies in one memory, with an erase sweep after reset.
module rel_store #(
  parameter int SLOTS      = rel_pkg::DEF_SLOTS,
  parameter int MAX_COPIES = rel_pkg::DEF_MAX_COPIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [rel_pkg::CNT_W-1:0]   wr_copy,
  input  logic [$clog2(SLOTS)-1:0]    wr_slot,
  input  logic [rel_pkg::CODE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [rel_pkg::CNT_W-1:0]   rd_copy,
  input  logic [$clog2(SLOTS)-1:0]    rd_slot,
  output logic [rel_pkg::CODE_W-1:0]  rd_data,
  output logic                        busy
);
  import rel_pkg::*;

  localparam int DEPTH = SLOTS * MAX_COPIES;
  localparam int AW    = $clog2(DEPTH);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  // copy-major layout
  assign waddr = AW'(32'(wr_copy) * 32'(SLOTS) + 32'(wr_slot));
  assign raddr = AW'(32'(rd_copy) * 32'(SLOTS) + 32'(rd_slot));

  // erase sweep, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // single write port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= ERASED;
    end else if (wr_en) begin
      mem[waddr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

[design/rel_vote.sv]
// Majority vote unit: one copy word compared per step.
module rel_vote (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [rel_pkg::CODE_W-1:0]  value,
  output rel_pkg::vote_res_t          res
);
  import rel_pkg::*;

  logic [CODE_W-1:0] cand;
  logic [CNT_W-1:0]  freq;
  logic [CNT_W-1:0]  mis;
  logic              chosen;

  // candidate starts erased; a miss at zero count takes the new word
  always_ff @(posedge clk) begin
    if (rst || start) begin
      cand   <= ERASED;
      freq   <= '0;
      mis    <= '0;
      chosen <= 1'b0;
    end else if (step) begin
      if (value == cand) begin
        freq <= freq + CNT_W'(1);
      end else begin
        mis <= mis + CNT_W'(1);
        if (freq == '0) begin
          cand   <= value;
          chosen <= 1'b1;
        end else begin
          freq <= freq - CNT_W'(1);
        end
      end
    end
  end

  assign res.cand   = cand;
  assign res.chosen = chosen;
  assign res.fix    = (mis >= CNT_W'(2));

endmodule
